>>> src/wvpid_pkg.sv
// ============================================================================
// wvpid_pkg
// Shared types and constants of the per-wheel PID velocity controller.
// ============================================================================
`default_nettype none

package wvpid_pkg;

    // Field widths.
    localparam int WHEEL_W = 2;
    localparam int VEL_W   = 16;
    localparam int GAIN_W  = 32;
    localparam int DRIVE_W = 15;
    localparam int CFG_W   = 2;

    // Internal term widths.
    localparam int ERR_W   = 11;  // error clamped to +/-1000
    localparam int DSTEP_W = 6;   // speed change clamped to +/-30
    localparam int DER_W   = 16;  // derivative term, +/-30000
    localparam int INTEG_W = 18;  // ten times the integral, +/-100000
    localparam int MEM_W   = INTEG_W + VEL_W;

    // Product and sum widths (gain widened by one bit to stay signed).
    localparam int P_W = GAIN_W + 1 + ERR_W;
    localparam int I_W = GAIN_W + 1 + INTEG_W;
    localparam int D_W = GAIN_W + 1 + DER_W;
    localparam int S_W = 53;

    // Division by ten times 2^24: keep bits [40:24] of the magnitude, then
    // multiply by the reciprocal of ten scaled by 2^20.
    localparam int QT_LSB  = 24;
    localparam int QT_W    = 17;
    localparam int RECIP_W = 17;
    localparam int QP_W    = QT_W + RECIP_W;
    localparam int RECIP_SHIFT = 20;
    localparam int QUOT_W  = 14;
    localparam logic [RECIP_W-1:0] RECIP_TEN = 17'd104858;

    // Limits.
    localparam logic signed [ERR_W-1:0]   ERR_MAX   = 11'sd1000;
    localparam logic signed [DSTEP_W-1:0] DSTEP_MAX = 6'sd30;
    localparam logic signed [DER_W-1:0]   DER_SCALE = 16'sd1000;
    localparam logic signed [INTEG_W-1:0] INTEG_MAX = 18'sd100000;
    localparam logic signed [P_W-1:0]     P_MAX     = 44'sd167772160000;
    localparam logic [S_W-1:0]            SAT_LIM   = 53'd1677721600000;
    localparam logic signed [DRIVE_W-1:0] DRIVE_MAX = 15'sd10000;

    // Configuration register indexes and reset values.
    localparam logic [CFG_W-1:0] REG_PROP_GAIN  = 2'd0;
    localparam logic [CFG_W-1:0] REG_INTEG_GAIN = 2'd1;
    localparam logic [CFG_W-1:0] REG_DERIV_GAIN = 2'd2;

    localparam logic [GAIN_W-1:0] PROP_GAIN_RST  = 32'd117440512;
    localparam logic [GAIN_W-1:0] INTEG_GAIN_RST = 32'd8388608;
    localparam logic [GAIN_W-1:0] DERIV_GAIN_RST = 32'd1678;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_MUL,
        ST_SUM,
        ST_FIN
    } state_t;

    typedef struct packed {
        logic mul_en;
        logic sum_en;
    } gain_ctrl_t;

endpackage

`default_nettype wire

>>> src/wvpid_ram.sv
// ============================================================================
// wvpid_ram
// Generic single-write, single-read RAM with a registered read port.
// ============================================================================
`default_nettype none

module wvpid_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 4,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

>>> src/wvpid_update.sv
// ============================================================================
// wvpid_update
// State update of one wheel: clamped error, derivative and integrator.
// ============================================================================
`default_nettype none

module wvpid_update import wvpid_pkg::*; (
    input  wire logic signed [VEL_W-1:0]   target_velocity,
    input  wire logic signed [VEL_W-1:0]   actual_velocity,
    input  wire logic signed [VEL_W-1:0]   prev_velocity,
    input  wire logic signed [INTEG_W-1:0] integ_in,
    output logic signed [ERR_W-1:0]        err,
    output logic signed [DER_W-1:0]        deriv,
    output logic signed [INTEG_W-1:0]      integ_out
);

    logic signed [VEL_W:0]     diff_err;
    logic signed [VEL_W:0]     diff_vel;
    logic signed [DSTEP_W-1:0] dstep;
    logic signed [INTEG_W:0]   integ_sum;

    always_comb
    begin
        diff_err = (VEL_W+1)'(target_velocity) - (VEL_W+1)'(actual_velocity);
        diff_vel = (VEL_W+1)'(actual_velocity) - (VEL_W+1)'(prev_velocity);

        if (diff_err > (VEL_W+1)'(ERR_MAX))
            err = ERR_MAX;
        else if (diff_err < -(VEL_W+1)'(ERR_MAX))
            err = -ERR_MAX;
        else
            err = ERR_W'(diff_err);

        // Clamping the speed change to 30 before scaling by 1000 gives the
        // same result as clamping the scaled value to 30000.
        if (diff_vel > (VEL_W+1)'(DSTEP_MAX))
            dstep = DSTEP_MAX;
        else if (diff_vel < -(VEL_W+1)'(DSTEP_MAX))
            dstep = -DSTEP_MAX;
        else
            dstep = DSTEP_W'(diff_vel);
        deriv = DER_W'(dstep) * DER_SCALE;

        integ_sum = (INTEG_W+1)'(integ_in) + (INTEG_W+1)'(err);
        if (integ_sum > (INTEG_W+1)'(INTEG_MAX))
            integ_out = INTEG_MAX;
        else if (integ_sum < -(INTEG_W+1)'(INTEG_MAX))
            integ_out = -INTEG_MAX;
        else
            integ_out = INTEG_W'(integ_sum);
    end

endmodule

`default_nettype wire

>>> src/wvpid_gain.sv
// ============================================================================
// wvpid_gain
// Gain multiplication, weighted sum and scaling to the saturated drive.
// ============================================================================
`default_nettype none

module wvpid_gain import wvpid_pkg::*; (
    input  wire logic                      clk,
    input  wire gain_ctrl_t                ctrl,
    input  wire logic [GAIN_W-1:0]         prop_gain,
    input  wire logic [GAIN_W-1:0]         integ_gain,
    input  wire logic [GAIN_W-1:0]         deriv_gain,
    input  wire logic signed [ERR_W-1:0]   err,
    input  wire logic signed [INTEG_W-1:0] integ,
    input  wire logic signed [DER_W-1:0]   deriv,
    output logic signed [DRIVE_W-1:0]      drive
);

    logic signed [P_W-1:0] p_prod_reg;
    logic signed [I_W-1:0] i_prod_reg;
    logic signed [D_W-1:0] d_prod_reg;
    logic signed [S_W-1:0] sum_reg;

    logic signed [P_W-1:0]     p_clamp;
    logic signed [S_W-1:0]     p_ext;
    logic signed [S_W-1:0]     d_ext;
    logic signed [S_W-1:0]     sum_next;
    logic [S_W-1:0]            mag;
    logic [QT_W-1:0]           quot_in;
    logic [QP_W-1:0]           quot_prod;
    logic signed [DRIVE_W-1:0] drive_mag;

    // Products of the gains, registered.
    always_ff @(posedge clk)
    begin
        if (ctrl.mul_en)
        begin
            p_prod_reg <= $signed({1'b0, prop_gain}) * err;
            i_prod_reg <= $signed({1'b0, integ_gain}) * integ;
            d_prod_reg <= $signed({1'b0, deriv_gain}) * deriv;
        end
    end

    // Sum in units of 2^-24 / 10.
    always_comb
    begin
        if (p_prod_reg > P_MAX)
            p_clamp = P_MAX;
        else if (p_prod_reg < -P_MAX)
            p_clamp = -P_MAX;
        else
            p_clamp = p_prod_reg;
        p_ext    = S_W'(p_clamp);
        d_ext    = S_W'(d_prod_reg);
        sum_next = (p_ext <<< 3) + (p_ext <<< 1) + S_W'(i_prod_reg)
                 + (d_ext <<< 3) + (d_ext <<< 1);
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.sum_en)
        begin
            sum_reg <= sum_next;
        end
    end

    // Truncation toward zero: divide the magnitude, then restore the sign.
    always_comb
    begin
        mag       = sum_reg[S_W-1] ? S_W'(-sum_reg) : S_W'(sum_reg);
        quot_in   = mag[QT_LSB +: QT_W];
        quot_prod = QP_W'(quot_in) * QP_W'(RECIP_TEN);
        if (mag >= SAT_LIM)
            drive_mag = DRIVE_MAX;
        else
            drive_mag = DRIVE_W'(quot_prod[RECIP_SHIFT +: QUOT_W]);
        drive = sum_reg[S_W-1] ? -drive_mag : drive_mag;
    end

endmodule

`default_nettype wire

>>> src/wheel_velocity_pid_top.sv
// ============================================================================
// wheel_velocity_pid_top
// Per-wheel PID velocity controller with clamped integrator.
// ============================================================================
// Usage: each input transfer carries a wheel index with its target and
// measured speed; it produces exactly one output transfer with the same
// wheel index and the saturated current command for that motor.
// Both channels use valid and stall: a transfer happens at a rising clock
// edge with valid high and stall low.
// The item passes in turn through the read-modify-write of the wheel state
// RAM, the gain multipliers, the weighted sum and the final scaling; then
// out_valid rises as the result is loaded into the output register. The
// block takes no new item before it is through with the last: the next
// item is taken at the earliest in the cycle that loads the result.
// When the receiver stalls, the finished result waits in the output
// register; the block still takes the next item and runs it until its own
// result is ready, then holds until the register frees up.
// Reset loads the default gains and marks every wheel entry as empty, so
// each wheel starts with zero integrator and zero previous speed; the
// entries need no clearing pass. An index not below NUM_WHEELS yields a
// drive of zero and leaves all state alone. Gains must be written through
// cfg_we / cfg_index / cfg_data only while idle, not enforced by the block.
// ============================================================================
`default_nettype none

module wheel_velocity_pid_top import wvpid_pkg::*; #(
    parameter int NUM_WHEELS = 4
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      in_valid,
    output logic                           in_stall,
    input  wire logic [WHEEL_W-1:0]        wheel,
    input  wire logic signed [VEL_W-1:0]   target_velocity,
    input  wire logic signed [VEL_W-1:0]   actual_velocity,
    output logic                           out_valid,
    input  wire logic                      out_stall,
    output logic [WHEEL_W-1:0]             wheel_out,
    output logic signed [DRIVE_W-1:0]      drive_current,
    input  wire logic                      cfg_we,
    input  wire logic [CFG_W-1:0]          cfg_index,
    input  wire logic [GAIN_W-1:0]         cfg_data
);

    localparam int ADDR_W    = (NUM_WHEELS > 1) ? $clog2(NUM_WHEELS) : 1;
    localparam int ENTRIES   = 2 ** ADDR_W;
    localparam int CMP_W     = 6;

    // Gain registers.
    logic [GAIN_W-1:0] prop_gain_reg;
    logic [GAIN_W-1:0] integ_gain_reg;
    logic [GAIN_W-1:0] deriv_gain_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prop_gain_reg  <= PROP_GAIN_RST;
            integ_gain_reg <= INTEG_GAIN_RST;
            deriv_gain_reg <= DERIV_GAIN_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_PROP_GAIN:  prop_gain_reg  <= cfg_data;
                REG_INTEG_GAIN: integ_gain_reg <= cfg_data;
                REG_DERIV_GAIN: deriv_gain_reg <= cfg_data;
                default:        ;
            endcase
        end
    end

    // Control.
    state_t     state_reg;
    state_t     state_next;
    logic       in_accept;
    logic       fin_ok;
    logic       fin_load;
    logic       upd_en;
    logic       wr_en;
    gain_ctrl_t gain_ctrl;

    assign in_accept = in_valid && !in_stall;
    assign fin_ok    = !out_valid || !out_stall;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (in_accept) state_next = ST_READ;
            ST_READ: state_next = ST_MUL;
            ST_MUL:  state_next = ST_SUM;
            ST_SUM:  state_next = ST_FIN;
            ST_FIN:
            begin
                if (fin_ok)
                    state_next = in_accept ? ST_READ : ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_stall         = 1'b1;
        fin_load         = 1'b0;
        upd_en           = 1'b0;
        gain_ctrl.mul_en = 1'b0;
        gain_ctrl.sum_en = 1'b0;
        unique case (state_reg)
            ST_IDLE: in_stall = 1'b0;
            ST_READ: upd_en = 1'b1;
            ST_MUL:  gain_ctrl.mul_en = 1'b1;
            ST_SUM:  gain_ctrl.sum_en = 1'b1;
            ST_FIN:
            begin
                fin_load = fin_ok;
                in_stall = !fin_ok;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // Captured item.
    logic [ADDR_W-1:0]         in_addr;
    logic                      in_range;
    logic [WHEEL_W-1:0]        wheel_reg;
    logic [ADDR_W-1:0]         addr_reg;
    logic signed [VEL_W-1:0]   target_reg;
    logic signed [VEL_W-1:0]   actual_reg;
    logic                      in_range_reg;
    logic                      entry_valid_reg;
    logic [ENTRIES-1:0]        valid_reg;

    assign in_addr  = ADDR_W'(wheel);
    assign in_range = CMP_W'(wheel) < CMP_W'(NUM_WHEELS);
    assign wr_en    = upd_en && in_range_reg;

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            wheel_reg       <= wheel;
            addr_reg        <= in_addr;
            target_reg      <= target_velocity;
            actual_reg      <= actual_velocity;
            in_range_reg    <= in_range;
            entry_valid_reg <= in_range && valid_reg[in_addr];
        end
    end

    // An entry never written since reset reads as zero state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (wr_en)
            valid_reg[addr_reg] <= 1'b1;
    end

    // Wheel state RAM: {integrator, previous velocity}. The read is issued
    // in the transfer cycle and written back in the following cycle; only
    // one item is in this part at a time, so no forwarding is needed.
    logic [MEM_W-1:0]            rd_data;
    logic [MEM_W-1:0]            wr_data;
    logic signed [INTEG_W-1:0]   integ_old;
    logic signed [VEL_W-1:0]     prev_old;
    logic signed [ERR_W-1:0]     err_w;
    logic signed [DER_W-1:0]     deriv_w;
    logic signed [INTEG_W-1:0]   integ_w;

    wvpid_ram #(
        .WIDTH (MEM_W),
        .DEPTH (NUM_WHEELS),
        .ADDR_W(ADDR_W)
    ) u_ram (
        .clk  (clk),
        .we   (wr_en),
        .waddr(addr_reg),
        .wdata(wr_data),
        .raddr(in_addr),
        .rdata(rd_data)
    );

    assign integ_old = entry_valid_reg ? rd_data[VEL_W +: INTEG_W] : '0;
    assign prev_old  = entry_valid_reg ? rd_data[VEL_W-1:0] : '0;
    assign wr_data   = {integ_w, actual_reg};

    wvpid_update u_update (
        .target_velocity(target_reg),
        .actual_velocity(actual_reg),
        .prev_velocity  (prev_old),
        .integ_in       (integ_old),
        .err            (err_w),
        .deriv          (deriv_w),
        .integ_out      (integ_w)
    );

    logic signed [ERR_W-1:0]   err_reg;
    logic signed [DER_W-1:0]   deriv_reg;
    logic signed [INTEG_W-1:0] integ_reg;

    always_ff @(posedge clk)
    begin
        if (upd_en)
        begin
            err_reg   <= err_w;
            deriv_reg <= deriv_w;
            integ_reg <= integ_w;
        end
    end

    logic signed [DRIVE_W-1:0] drive_w;

    wvpid_gain u_gain (
        .clk       (clk),
        .ctrl      (gain_ctrl),
        .prop_gain (prop_gain_reg),
        .integ_gain(integ_gain_reg),
        .deriv_gain(deriv_gain_reg),
        .err       (err_reg),
        .integ     (integ_reg),
        .deriv     (deriv_reg),
        .drive     (drive_w)
    );

    // Output register.
    logic                      out_valid_reg;
    logic [WHEEL_W-1:0]        wheel_out_reg;
    logic signed [DRIVE_W-1:0] drive_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (fin_load)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (fin_load)
        begin
            wheel_out_reg <= wheel_reg;
            drive_reg     <= in_range_reg ? drive_w : '0;
        end
    end

    assign out_valid     = out_valid_reg;
    assign wheel_out     = wheel_out_reg;
    assign drive_current = drive_reg;

endmodule

`default_nettype wire

>>> src/wvpid_checker.sv
// ============================================================================
// wvpid_checker
// Port-level checks of the PID velocity controller.
// ============================================================================
`default_nettype none

module wvpid_checker import wvpid_pkg::*; (
    input wire logic                    clk,
    input wire logic                    rst_n,
    input wire logic                    in_valid,
    input wire logic                    in_stall,
    input wire logic [WHEEL_W-1:0]      wheel,
    input wire logic                    out_valid,
    input wire logic                    out_stall,
    input wire logic [WHEEL_W-1:0]      wheel_out,
    input wire logic signed [DRIVE_W-1:0] drive_current
);

    // A stalled result holds.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(wheel_out)
                                   && $stable(drive_current))
        else $error("stalled result changed");

    // While out_valid is high, the drive is within its saturation limits.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (drive_current <= DRIVE_MAX) && (drive_current >= -DRIVE_MAX))
        else $error("drive out of range");

    // One item at a time: the cycle after a transfer the input stalls.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input taken while an item is at work");

    // A fresh result matches an earlier input transfer and its wheel index.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && !in_stall, 5)
                             && (wheel_out == $past(wheel, 5)))
        else $error("result does not match its input transfer");

endmodule

bind wheel_velocity_pid_top wvpid_checker u_checker (.*);

`default_nettype wire
